// ===== rtl/lfmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfmd_pkg: shared types and constants of the length-framed message deframer
// Result kinds, configuration register indexes and the command metadata
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package lfmd_pkg;

	localparam int unsigned HEADER_BYTES_DEF = 16;
	localparam logic [15:0] DEFAULT_VERSION  = 16'd10;
	localparam int unsigned CFG_DATA_W       = 16;
	localparam int unsigned CFG_INDEX_W      = 3;
	localparam int unsigned MAX_VERSIONS     = 4;
	localparam int unsigned QUEUE_DEPTH      = 2;

	typedef enum logic [1:0] {
		KIND_MSG    = 2'd0,
		KIND_BADVER = 2'd1,
		KIND_SHORT  = 2'd2
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COUNT = 3'd0,
		CFG_VER_A = 3'd1,
		CFG_VER_B = 3'd2,
		CFG_VER_C = 3'd3,
		CFG_VER_D = 3'd4
	} cfg_index_t;

	// One request for the back end: a single result, or a whole header burst.
	typedef struct packed {
		kind_t       kind;
		logic        hdr;
		logic        first;
		logic        last;
		logic [31:0] idx;
	} cmd_meta_t;

	localparam int unsigned META_W = $bits(cmd_meta_t);

endpackage

// ===== rtl/length_framed_message_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// length_framed_message_deframer_unit: byte-stream message deframer
// Finds length-framed messages with a version check and byte resync.
// ----------------------------------------------------------------------------
// Path: the first result of a byte is written into the queue, then loaded
//   into the back-end registers, from which it shows.
// Throughput: one byte per cycle while the two-entry request queue has room;
//   a full header plays out as HEADER_BYTES results, one per cycle while pop
//   is held, so the output side sets the pace when headers come back to back.
// Reset: asynchronous; clears window fill, body state, message count, the
//   version registers and the queue. Header window bytes are not cleared.
// ----------------------------------------------------------------------------
module length_framed_message_deframer_unit #(
	parameter int unsigned HEADER_BYTES = lfmd_pkg::HEADER_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// byte input side
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       in_byte,
	// result side
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       kind,
	output logic [7:0]                       out_byte,
	output logic                             msg_first,
	output logic                             msg_last,
	output logic [31:0]                      msg_index,
	output logic                             run_last,
	// configuration writes
	input  logic                             cfg_we,
	input  logic [lfmd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lfmd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import lfmd_pkg::*;

	localparam int unsigned WIN_W = HEADER_BYTES * 8;
	localparam int unsigned REQ_W = META_W + WIN_W;

	// front -> queue request
	logic             take;
	logic             fq_push;
	cmd_meta_t        fq_meta;
	logic [WIN_W-1:0] fq_win;

	// queue -> back request
	logic             qb_valid;
	logic             qb_pop;
	logic [REQ_W-1:0] qb_data;
	cmd_meta_t        qb_meta;
	logic [WIN_W-1:0] qb_win;

	// every accepted byte waits for a queue slot, whether or not it makes results
	assign take = push && !full;

	lfmd_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_byte  (in_byte),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.q_push   (fq_push),
		.q_meta   (fq_meta),
		.q_win    (fq_win)
	);

	lfmd_queue #(
		.WIDTH(REQ_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data ({fq_meta, fq_win}),
		.rd_en   (qb_pop),
		.rd_data (qb_data),
		.rd_valid(qb_valid),
		.full    (full)
	);

	assign qb_meta = qb_data[REQ_W-1:WIN_W];
	assign qb_win  = qb_data[WIN_W-1:0];

	lfmd_back #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (qb_valid),
		.q_meta   (qb_meta),
		.q_win    (qb_win),
		.q_pop    (qb_pop),
		.pop      (pop),
		.empty    (empty),
		.kind     (kind),
		.out_byte (out_byte),
		.msg_first(msg_first),
		.msg_last (msg_last),
		.msg_index(msg_index),
		.run_last (run_last)
	);

	// only message bytes open a message
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && msg_first |-> (kind == KIND_MSG))
		else $error("deframer: first flag on a drop result");

	// drops are single results, never part of a message
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind != KIND_MSG) |-> (run_last && !msg_last))
		else $error("deframer: drop result not a lone result");

	// a header burst plays out without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !run_last |=> !empty)
		else $error("deframer: gap inside a header burst");

endmodule

// ===== rtl/lfmd_queue.sv =====
// ----------------------------------------------------------------------------
// lfmd_queue: short request queue between front end and back end
// Register-based FIFO; lets the front keep accepting bytes while a header
// burst drains on the output side.
// ----------------------------------------------------------------------------
module lfmd_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = lfmd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             rd_valid,
	output logic             full
);
	import lfmd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_valid = (count_q != '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("lfmd_queue: occupancy above depth");

endmodule

// ===== rtl/lfmd_front.sv =====
// ----------------------------------------------------------------------------
// lfmd_front: byte intake, header window and message classification
// Shifts bytes into the header window, judges a full window against the
// accepted versions and the length rule, tracks body bytes and message count.
// ----------------------------------------------------------------------------
module lfmd_front #(
	parameter int unsigned HEADER_BYTES = lfmd_pkg::HEADER_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [7:0]                          in_byte,
	input  logic                                cfg_we,
	input  logic [lfmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lfmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                q_push,
	output lfmd_pkg::cmd_meta_t                 q_meta,
	output logic [HEADER_BYTES*8-1:0]           q_win
);
	import lfmd_pkg::*;

	localparam int unsigned WIN_W  = HEADER_BYTES * 8;
	localparam int unsigned FILL_W = $clog2(HEADER_BYTES + 1);

	logic [2:0]        acc_count_q;
	logic [15:0]       acc_ver_q [MAX_VERSIONS];
	logic [WIN_W-1:0]  win_q;
	logic [FILL_W-1:0] fill_q;
	logic              in_body_q;
	logic [15:0]       remain_q;
	logic [31:0]       count_q;

	logic [WIN_W-1:0]  win_next;
	logic [FILL_W-1:0] fill_inc;
	logic              win_full;
	logic [15:0]       version;
	logic [15:0]       length;
	logic [15:0]       body_len;
	logic              ver_ok;
	logic              len_short;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_count_q <= '0;
			for (int i = 0; i < MAX_VERSIONS; i++) begin
				acc_ver_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNT: acc_count_q  <= cfg_wdata[2:0];
				CFG_VER_A: acc_ver_q[0] <= cfg_wdata;
				CFG_VER_B: acc_ver_q[1] <= cfg_wdata;
				CFG_VER_C: acc_ver_q[2] <= cfg_wdata;
				CFG_VER_D: acc_ver_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// new byte enters at the top; byte 0 of the window is the oldest
	assign win_next  = {in_byte, win_q[WIN_W-1:8]};
	assign fill_inc  = fill_q + 1'b1;
	assign win_full  = (fill_inc == FILL_W'(HEADER_BYTES));
	assign version   = {win_next[7:0], win_next[15:8]};
	assign length    = {win_next[23:16], win_next[31:24]};
	assign body_len  = length - 16'(HEADER_BYTES);
	assign len_short = (length < 16'(HEADER_BYTES));

	// counts of five to seven behave as four
	always_comb begin
		ver_ok = 1'b0;
		if (acc_count_q == 3'd0) begin
			ver_ok = (version == DEFAULT_VERSION);
		end else begin
			for (int i = 0; i < MAX_VERSIONS; i++) begin
				if (acc_count_q > 3'(i) && acc_ver_q[i] == version) begin
					ver_ok = 1'b1;
				end
			end
		end
	end

	always_comb begin
		q_push       = 1'b0;
		q_meta.kind  = KIND_MSG;
		q_meta.hdr   = 1'b0;
		q_meta.first = 1'b0;
		q_meta.last  = 1'b0;
		q_meta.idx   = count_q;
		q_win        = {{(WIN_W-8){1'b0}}, in_byte};
		if (take) begin
			if (in_body_q) begin
				q_push      = 1'b1;
				q_meta.last = (remain_q <= 16'd1);
			end else if (win_full) begin
				q_push = 1'b1;
				q_win  = {{(WIN_W-8){1'b0}}, win_next[7:0]};
				if (!ver_ok) begin
					q_meta.kind = KIND_BADVER;
				end else if (len_short) begin
					q_meta.kind = KIND_SHORT;
				end else begin
					q_meta.hdr   = 1'b1;
					q_meta.first = 1'b1;
					q_meta.last  = (body_len == 16'd0);
					q_meta.idx   = count_q + 32'd1;
					q_win        = win_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			in_body_q <= 1'b0;
			remain_q  <= '0;
			count_q   <= '0;
		end else if (take) begin
			if (in_body_q) begin
				remain_q <= remain_q - 16'd1;
				if (remain_q == 16'd1) begin
					in_body_q <= 1'b0;
				end
			end else if (!win_full) begin
				fill_q <= fill_inc;
			end else if (!ver_ok) begin
				fill_q <= FILL_W'(HEADER_BYTES - 1);
			end else if (len_short) begin
				fill_q <= '0;
			end else begin
				fill_q    <= '0;
				count_q   <= count_q + 32'd1;
				remain_q  <= body_len;
				in_body_q <= (body_len != 16'd0);
			end
		end
	end

	// window contents need no reset
	always_ff @(posedge clk) begin
		if (take && !in_body_q) begin
			win_q <= win_next;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (remain_q != 16'd0))
		else $error("lfmd_front: in body with nothing left");

endmodule

// ===== rtl/lfmd_back.sv =====
// ----------------------------------------------------------------------------
// lfmd_back: result sequencer
// Takes requests from the queue and presents results; a header request is
// played out one byte per pop from a shifting copy of the window.
// ----------------------------------------------------------------------------
module lfmd_back #(
	parameter int unsigned HEADER_BYTES = lfmd_pkg::HEADER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  lfmd_pkg::cmd_meta_t         q_meta,
	input  logic [HEADER_BYTES*8-1:0]   q_win,
	output logic                        q_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [1:0]                  kind,
	output logic [7:0]                  out_byte,
	output logic                        msg_first,
	output logic                        msg_last,
	output logic [31:0]                 msg_index,
	output logic                        run_last
);
	import lfmd_pkg::*;

	localparam int unsigned WIN_W = HEADER_BYTES * 8;
	localparam int unsigned CNT_W = $clog2(HEADER_BYTES);

	logic             valid_q;
	cmd_meta_t        meta_q;
	logic [WIN_W-1:0] win_q;
	logic [CNT_W-1:0] cnt_q;
	logic             at_end;
	logic             take_out;

	assign at_end   = !meta_q.hdr || (cnt_q == CNT_W'(HEADER_BYTES - 1));
	assign take_out = pop && valid_q;
	assign q_pop    = q_valid && (!valid_q || (take_out && at_end));

	assign empty     = !valid_q;
	assign kind      = meta_q.kind;
	assign out_byte  = win_q[7:0];
	assign msg_first = meta_q.hdr && (cnt_q == '0);
	assign msg_last  = meta_q.last && at_end;
	assign msg_index = meta_q.idx;
	assign run_last  = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (take_out) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			meta_q <= q_meta;
			win_q  <= q_win;
		end else if (take_out && !at_end) begin
			win_q <= {8'h00, win_q[WIN_W-1:8]};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !meta_q.hdr |-> (cnt_q == '0))
		else $error("lfmd_back: burst count on a single result");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: length-framed message deframer regression
// Streams framed messages, bad-version headers, short-length headers and
// line noise into the deframer under several accepted-version settings,
// with random idle on both sides and one long output stall. A local model
// of the deframer predicts every result; the monitor checks them in order.
// ----------------------------------------------------------------------------
module testbench;
	import lfmd_pkg::*;

	localparam int unsigned HB = HEADER_BYTES_DEF;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;     // covers the accept-to-result path through queue and back end
	localparam int HOLD_CYCLES   = 150;   // long output stall, fills the request queue
	localparam int IDLE_PCT      = 29;

	// one result as seen on the output side
	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		logic        is_first;
		logic        is_last;
		logic [31:0] index;
		logic        run_end;
	} deframe_result_t;

	// ---- DUT signals, all inputs known from time zero ----
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   push      = 1'b0;
	logic                   full;
	logic [7:0]             in_byte   = 8'h00;
	logic                   empty;
	logic                   pop       = 1'b0;
	logic [1:0]             kind;
	logic [7:0]             out_byte;
	logic                   msg_first;
	logic                   msg_last;
	logic [31:0]            msg_index;
	logic                   run_last;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_COUNT;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// ---- deframer model state (mirrors the block) ----
	logic [7:0]  win_bytes [HB];
	int unsigned win_fill  = 0;
	logic [15:0] body_left = '0;
	bit          in_body   = 1'b0;
	logic [31:0] msg_count = '0;
	logic [2:0]  cfg_count = '0;
	logic [15:0] cfg_ver [MAX_VERSIONS] = '{default: '0};

	// ---- stimulus and scoreboard ----
	logic [7:0]      pending_bytes [$];     // bytes waiting for the driver
	deframe_result_t expected_results [$];  // predicted results, oldest first
	deframe_result_t oldest;

	bit steady        = 1'b0;  // no random idling on either side
	int hold_requests = 0;     // bumped to ask the monitor for a long stall
	int hold_seen     = 0;
	int hold_left     = 0;

	int cycle_count    = 0;
	int mismatch_count = 0;
	int bytes_accepted = 0;
	int results_seen   = 0;
	int msgs_framed    = 0;
	int version_drops  = 0;
	int length_drops   = 0;

	length_framed_message_deframer_unit #(
		.HEADER_BYTES(HB)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.empty    (empty),
		.pop      (pop),
		.kind     (kind),
		.out_byte (out_byte),
		.msg_first(msg_first),
		.msg_last (msg_last),
		.msg_index(msg_index),
		.run_last (run_last),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, expected_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------------

	// count 0 means only the default version; counts above four act as four
	function automatic bit version_accepted(logic [15:0] v);
		int unsigned n;
		int          i;
		bit          hit;
		n   = (cfg_count > 3'd4) ? 4 : cfg_count;
		hit = 1'b0;
		if (n == 0)
			return v == DEFAULT_VERSION;
		for (i = 0; i < n; i++)
			if (cfg_ver[i] == v)
				hit = 1'b1;
		return hit;
	endfunction

	task automatic add_result(kind_t k, logic [7:0] d, logic f, logic l, logic run_end);
		deframe_result_t r;
		r.kind     = k;
		r.data     = d;
		r.is_first = f;
		r.is_last  = l;
		r.index    = msg_count;
		r.run_end  = run_end;
		expected_results.push_back(r);
	endtask

	// One accepted stream byte in, zero or more predicted results out.
	task automatic predict_deframe(logic [7:0] b);
		logic [15:0] ver;
		logic [15:0] len;
		int          i;
		if (in_body) begin
			add_result(KIND_MSG, b, 1'b0, (body_left <= 16'd1), 1'b1);
			if (body_left > 0)
				body_left--;
			if (body_left == 0)
				in_body = 1'b0;
			return;
		end
		win_bytes[win_fill] = b;
		win_fill++;
		if (win_fill < HB)
			return;
		ver = {win_bytes[0], win_bytes[1]};
		len = {win_bytes[2], win_bytes[3]};
		if (!version_accepted(ver)) begin
			// resync: drop the oldest byte, slide the window by one
			add_result(KIND_BADVER, win_bytes[0], 1'b0, 1'b0, 1'b1);
			for (i = 0; i < HB - 1; i++)
				win_bytes[i] = win_bytes[i + 1];
			win_fill = HB - 1;
			version_drops++;
		end else if (len < HB) begin
			add_result(KIND_SHORT, win_bytes[0], 1'b0, 1'b0, 1'b1);
			win_fill = 0;
			length_drops++;
		end else begin
			// whole header plays out at once; header-only message ends on its last byte
			msg_count++;
			body_left = len - 16'(HB);
			in_body   = (body_left != 0);
			for (i = 0; i < HB; i++)
				add_result(KIND_MSG, win_bytes[i], (i == 0), (i == HB - 1) && !in_body,
					(i == HB - 1));
			win_fill = 0;
			msgs_framed++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Input side: driver changes push/in_byte on the falling edge,
	// acceptance is taken at the rising edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n || pending_bytes.size() == 0 ||
				(!steady && $urandom_range(0, 99) < IDLE_PCT)) begin
			push <= 1'b0;
		end else begin
			push    <= 1'b1;
			in_byte <= pending_bytes[0];
		end
	end

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			predict_deframe(in_byte);
			void'(pending_bytes.pop_front());
			bytes_accepted++;
		end
	end

	// ------------------------------------------------------------------------
	// Result side: pop with random stalls, plus one long hold on request
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= arst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic report_mismatch(string what);
		if (mismatch_count < 30)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unpredicted result kind %0d byte %02h index %0d",
					kind, out_byte, msg_index));
			end else begin
				oldest = expected_results.pop_front();
				if (kind !== oldest.kind || out_byte !== oldest.data ||
						msg_first !== oldest.is_first || msg_last !== oldest.is_last ||
						msg_index !== oldest.index || run_last !== oldest.run_end)
					report_mismatch($sformatf(
						"got k%0d %02h f%0b l%0b #%0d r%0b, want k%0d %02h f%0b l%0b #%0d r%0b",
						kind, out_byte, msg_first, msg_last, msg_index, run_last,
						oldest.kind, oldest.data, oldest.is_first, oldest.is_last,
						oldest.index, oldest.run_end));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stream building
	// ------------------------------------------------------------------------
	task automatic write_reg(cfg_index_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_COUNT)
			cfg_count = val[2:0];
		else
			cfg_ver[int'(idx) - 1] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_header(logic [15:0] ver, logic [15:0] len);
		pending_bytes.push_back(ver[15:8]);
		pending_bytes.push_back(ver[7:0]);
		pending_bytes.push_back(len[15:8]);
		pending_bytes.push_back(len[7:0]);
		repeat (HB - 4)
			pending_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic queue_message(logic [15:0] ver, int unsigned body);
		queue_header(ver, 16'(HB + body));
		repeat (body)
			pending_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [15:0] good_version();
		int unsigned n;
		n = (cfg_count > 3'd4) ? 4 : cfg_count;
		if (n == 0)
			return DEFAULT_VERSION;
		return cfg_ver[$urandom_range(0, n - 1)];
	endfunction

	function automatic logic [15:0] bad_version();
		logic [15:0] v;
		do
			v = 16'($urandom_range(0, 65535));
		while (version_accepted(v));
		return v;
	endfunction

	// mostly short bodies, now and then a longer one
	function automatic int unsigned body_size();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(40, 120);
		return $urandom_range(0, 12);
	endfunction

	// Mostly well-formed messages with random content; the rest are short-length
	// headers, bad-version headers (which resync byte by byte) and raw noise.
	task automatic queue_traffic(int unsigned target);
		int unsigned start;
		int unsigned pick;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				queue_message(good_version(), body_size());
			else if (pick < 72)
				queue_header(good_version(), 16'($urandom_range(0, HB - 1)));
			else if (pick < 85)
				queue_message(bad_version(), $urandom_range(0, 6));
			else
				repeat ($urandom_range(1, 5))
					pending_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// wait until every byte is in and every result is out, then let the pipe settle
	task automatic drain();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings (default version only):
		// one stray byte forces a version drop and a one-byte slide, which lands
		// on a header-only message; then a header whose length is one short.
		pending_bytes.push_back(8'hFF);
		queue_header(DEFAULT_VERSION, 16'(HB));
		pending_bytes[5] = 8'h00;
		pending_bytes[6] = 8'hFF;
		queue_header(DEFAULT_VERSION, 16'(HB - 1));
		drain();

		// The first seven bytes of a header with an unknown version sit in the window while the
		// versions change; the new set must apply when the window fills.
		pending_bytes.push_back(8'h12);
		pending_bytes.push_back(8'h34);
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'(HB + 4));
		repeat (3) pending_bytes.push_back(8'($urandom_range(0, 255)));
		drain();
		write_reg(CFG_COUNT, 16'd3);
		write_reg(CFG_VER_A, 16'h0000);
		write_reg(CFG_VER_B, 16'hFFFF);
		write_reg(CFG_VER_C, 16'h1234);
		write_reg(CFG_VER_D, 16'hABCD);   // configured but not counted yet
		repeat (HB - 7 + 4) pending_bytes.push_back(8'($urandom_range(0, 255)));
		queue_traffic(30);
		drain();

		// All four versions, no idling, and a long output stall up front so the
		// request queue fills and push gets back-pressured.
		write_reg(CFG_COUNT, 16'd4);
		write_reg(CFG_VER_A, 16'h0102);
		steady = 1'b1;
		hold_requests++;
		queue_traffic(35);
		drain();
		steady = 1'b0;

		// Count of seven behaves as four.
		write_reg(CFG_COUNT, 16'd7);
		write_reg(CFG_VER_B, DEFAULT_VERSION);
		write_reg(CFG_VER_C, 16'h8001);
		queue_traffic(30);
		drain();

		// Back to the default version only, with a stale list still loaded.
		write_reg(CFG_COUNT, 16'd0);
		queue_traffic(30);
		drain();

		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d predicted results never came",
				expected_results.size()));

		$display("stream of %0d bytes under five version settings, %0d results checked",
			bytes_accepted, results_seen);
		$display("%0d messages framed, %0d version drops, %0d short-length drops",
			msgs_framed, version_drops, length_drops);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
